// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CHECK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked once the previous edge was also outside reset
`define CHECK_AFTER_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (!$past(rst) |-> (prop))) \
    else $error(msg);

`endif

// ===== hdl/rmc_pkg.sv =====
package rmc_pkg;

  localparam int BoundW           = 63;
  localparam int CountW           = 32;
  localparam int MaxRangesDefault = 256;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // one word travelling down the cell chain; a holds the low bound or the identifier
  typedef struct packed {
    logic              valid;
    logic              func;
    logic [BoundW-1:0] a;
    logic [BoundW-1:0] b;
    logic              hit;
    logic              full;
  } rmc_word_t;

endpackage

// ===== hdl/rmc_in_if.sv =====
interface rmc_in_if import rmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BoundW-1:0] range_low;
  logic [BoundW-1:0] range_high;
  logic [BoundW-1:0] query_id;

  modport source (output valid, func, range_low, range_high, query_id, input ready);
  modport sink   (input valid, func, range_low, range_high, query_id, output ready);
endinterface

// ===== hdl/rmc_out_if.sv =====
interface rmc_out_if import rmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [CountW-1:0] hit_total;
  logic              table_full;

  modport source (output valid, hit, hit_total, table_full, input ready);
  modport sink   (input valid, hit, hit_total, table_full, output ready);
endinterface

// ===== hdl/rmc_cell.sv =====
module rmc_cell import rmc_pkg::*; #(
  parameter int MAX_RANGES = MaxRangesDefault,
  parameter int IDX        = 0,
  localparam int CntW      = $clog2(MAX_RANGES + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  rmc_word_t       word_in,
  input  logic [CntW-1:0] slot_in,
  output rmc_word_t       word_out,
  output logic [CntW-1:0] slot_out
);

  localparam logic [CntW-1:0] Slot = CntW'(IDX);

  logic [BoundW-1:0] lo;
  logic [BoundW-1:0] hi;
  logic              write_en;
  logic              match;
  rmc_word_t         word_next;

  // slot carries the fill level at entry: the write target for a load,
  // the number of live cells for a query
  assign write_en = adv && word_in.valid && (word_in.func == FuncLoad) && (slot_in == Slot);
  assign match    = (word_in.func == FuncQuery) && (Slot < slot_in) &&
                    (word_in.a >= lo) && (word_in.a <= hi);

  always_comb begin
    word_next     = word_in;
    word_next.hit = word_in.hit | match;
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      lo <= word_in.a;
      hi <= word_in.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else if (adv) begin
      word_out <= word_next;
      slot_out <= slot_in;
    end
  end

endmodule

// ===== hdl/rmc_tail.sv =====
`include "assert_macros.svh"

module rmc_tail import rmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rmc_word_t         last,
  input  logic              out_ready,
  output logic              adv,
  output logic              out_valid,
  output logic              hit,
  output logic [CountW-1:0] hit_total,
  output logic              table_full
);

  logic              is_hit;
  logic [CountW-1:0] hit_counter;
  logic [CountW-1:0] hit_counter_next;

  // the whole chain moves whenever the output register can take a word
  assign adv    = !out_valid || out_ready;
  assign is_hit = last.valid && (last.func == FuncQuery) && last.hit;

  always_comb begin
    hit_counter_next = hit_counter;
    if (is_hit && (hit_counter != '1)) begin
      hit_counter_next = hit_counter + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      hit_counter <= '0;
    end else if (adv) begin
      out_valid   <= last.valid;
      hit_counter <= hit_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last.valid) begin
      hit        <= (last.func == FuncQuery) && last.hit;
      table_full <= last.full;
    end
  end

  assign hit_total = hit_counter;

  `CHECK_AFTER_RST(a_count_step, (hit_counter == $past(hit_counter)) || (hit_counter == $past(hit_counter) + CountW'(1)), "hit count moved by more than one")
  `CHECK_CLK(a_hit_not_full, out_valid |-> !(hit && table_full), "word flagged both hit and full")
  `CHECK_CLK(a_stall_holds_count, (out_valid && !out_ready) |=> $stable(hit_counter) || $past(!out_valid || out_ready), "hit count changed during stall")

endmodule

// ===== hdl/range_membership_counter_core.sv =====
// channel | dir | fields                                  | handshake
// req     | in  | func, range_low, range_high, query_id   | valid / ready
// rsp     | out | hit, hit_total, table_full              | valid / ready
//
// one word accepted per cycle when rsp is not stalled; the result passes one register
// per range cell, then the output register
// a stalled rsp freezes the whole chain and drops req.ready in the same cycle
// rst is synchronous: clears the fill level, the hit count and all word valids;
// stored bounds are not cleared and are only compared once written

`include "assert_macros.svh"

module range_membership_counter_core import rmc_pkg::*; #(
  parameter int MAX_RANGES = MaxRangesDefault
) (
  input logic clk,
  input logic rst,
  rmc_in_if.sink    req,
  rmc_out_if.source rsp
);

  localparam int CntW = $clog2(MAX_RANGES + 1);
  localparam logic [CntW-1:0] FullLevel = CntW'(MAX_RANGES);

  logic            adv;
  logic            accept;
  logic [CntW-1:0] ranges_stored;
  logic [CntW-1:0] ranges_stored_next;
  rmc_word_t       chain [MAX_RANGES+1];
  logic [CntW-1:0] slots [MAX_RANGES+1];

  assign req.ready = adv;
  assign accept    = req.valid && adv;

  always_comb begin
    chain[0].valid = accept;
    chain[0].func  = req.func;
    chain[0].a     = (req.func == FuncQuery) ? req.query_id : req.range_low;
    chain[0].b     = req.range_high;
    chain[0].hit   = 1'b0;
    chain[0].full  = (req.func == FuncLoad) && (ranges_stored == FullLevel);
    slots[0]       = ranges_stored;
  end

  always_comb begin
    ranges_stored_next = ranges_stored;
    if (accept && (req.func == FuncLoad) && (ranges_stored != FullLevel)) begin
      ranges_stored_next = ranges_stored + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ranges_stored <= '0;
    end else begin
      ranges_stored <= ranges_stored_next;
    end
  end

  for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
    rmc_cell #(
      .MAX_RANGES (MAX_RANGES),
      .IDX        (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .word_in  (chain[k]),
      .slot_in  (slots[k]),
      .word_out (chain[k+1]),
      .slot_out (slots[k+1])
    );
  end

  rmc_tail u_tail (
    .clk        (clk),
    .rst        (rst),
    .last       (chain[MAX_RANGES]),
    .out_ready  (rsp.ready),
    .adv        (adv),
    .out_valid  (rsp.valid),
    .hit        (rsp.hit),
    .hit_total  (rsp.hit_total),
    .table_full (rsp.table_full)
  );

  `CHECK_CLK(a_level_bound, ranges_stored <= FullLevel, "fill level beyond table size")
  `CHECK_CLK(a_full_at_level,
             (rsp.valid && rsp.table_full) |-> (ranges_stored == FullLevel),
             "dropped load while table not full")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rmc_pkg::*;

  localparam int TableDepth  = MaxRangesDefault;
  localparam int RandomItems = 850;
  localparam logic [BoundW-1:0] BoundMax = {BoundW{1'b1}};
  localparam logic [CountW-1:0] TallyMax = {CountW{1'b1}};

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] hit_total;
    logic              table_full;
  } answer_t;

  // mirror of the range table and the hit tally, plus the answers still owed
  class range_match_board;
    logic [BoundW-1:0] bound_lo[$];
    logic [BoundW-1:0] bound_hi[$];
    logic [CountW-1:0] hit_tally;
    answer_t           owed_answers[$];
    int                depth;
    int                errors;

    function new(int table_depth);
      depth     = table_depth;
      hit_tally = '0;
      errors    = 0;
    endfunction

    function void note_request(logic func, logic [BoundW-1:0] lo, logic [BoundW-1:0] hi,
                               logic [BoundW-1:0] id);
      answer_t ans;
      ans = '0;
      if (func == FuncLoad) begin
        if (bound_lo.size() < depth) begin
          bound_lo.push_back(lo);
          bound_hi.push_back(hi);
        end else begin
          ans.table_full = 1'b1;
        end
      end else begin
        foreach (bound_lo[k]) begin
          if (id >= bound_lo[k] && id <= bound_hi[k]) ans.hit = 1'b1;
        end
        if (ans.hit && hit_tally != TallyMax) hit_tally++;
      end
      ans.hit_total = hit_tally;
      owed_answers.push_back(ans);
    endfunction

    function void check_response(logic hit, logic [CountW-1:0] hit_total, logic table_full);
      answer_t want;
      if (owed_answers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: hit %0d hit_total %0d table_full %0d",
                   hit, hit_total, table_full);
        return;
      end
      want = owed_answers.pop_front();
      if (hit !== want.hit || hit_total !== want.hit_total ||
          table_full !== want.table_full) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: hit %0d/%0d hit_total %0d/%0d table_full %0d/%0d (exp/got)",
                   want.hit, hit, want.hit_total, hit_total, want.table_full, table_full);
      end
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  rmc_in_if  req ();
  rmc_out_if rsp ();

  range_membership_counter_core #(
    .MAX_RANGES(TableDepth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  range_match_board board;
  int sender_gap_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiving side
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready)
        board.check_response(rsp.hit, rsp.hit_total, rsp.table_full);
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic [BoundW-1:0] random_bound();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 1)) return r[BoundW-1:0];
    return r[BoundW-1:0] >> $urandom_range(1, BoundW - 1);
  endfunction

  task automatic send_word(input logic func, input logic [BoundW-1:0] lo,
                           input logic [BoundW-1:0] hi, input logic [BoundW-1:0] id);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.func       <= func;
    req.range_low  <= lo;
    req.range_high <= hi;
    req.query_id   <= id;
    do @(posedge clk); while (!req.ready);
    board.note_request(func, lo, hi, id);
  endtask

  task automatic send_random_load();
    logic [BoundW-1:0] lo;
    logic [BoundW-1:0] hi;
    lo = random_bound();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: hi = lo + BoundW'($urandom_range(0, 1000));
      6, 7:             hi = random_bound();
      8:                hi = lo - 1 - BoundW'($urandom_range(0, 500));
      default:          hi = lo;
    endcase
    send_word(FuncLoad, lo, hi, random_bound());
  endtask

  task automatic send_random_query();
    logic [BoundW-1:0] id;
    logic [BoundW-1:0] lo;
    logic [BoundW-1:0] hi;
    longint unsigned   span;
    int                k;
    id = random_bound();
    if (board.bound_lo.size() > 0 && $urandom_range(0, 1)) begin
      // aim at or just beside a stored range
      k  = $urandom_range(0, board.bound_lo.size() - 1);
      lo = board.bound_lo[k];
      hi = board.bound_hi[k];
      case ($urandom_range(0, 4))
        0: id = lo;
        1: id = hi;
        2: id = lo - 1;
        3: id = hi + 1;
        default: begin
          if (lo <= hi) begin
            span = 64'(hi) - 64'(lo) + 64'd1;
            id   = lo + BoundW'({$urandom, $urandom} % span);
          end else begin
            id = lo;
          end
        end
      endcase
    end
    send_word(FuncQuery, random_bound(), random_bound(), id);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  initial begin
    board          = new(TableDepth);
    sender_gap_pct = 0;
    stall_pct      = 0;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.func       <= FuncLoad;
    req.range_low  <= '0;
    req.range_high <= '0;
    req.query_id   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_gap_pct = 18;
    stall_pct      = 79;

    // empty table misses everything
    send_word(FuncQuery, '0, '0, '0);
    send_word(FuncQuery, BoundMax, BoundMax, BoundMax);
    send_word(FuncLoad, '0, 63'd5, BoundMax);
    send_word(FuncLoad, BoundMax - 3, BoundMax, '0);
    send_word(FuncLoad, BoundMax, '0, 63'd77);
    send_word(FuncLoad, 63'd1000, 63'd1000, 63'd1000);
    send_word(FuncQuery, BoundMax, '0, '0);
    send_word(FuncQuery, '0, '0, 63'd5);
    send_word(FuncQuery, '0, '0, 63'd6);
    send_word(FuncQuery, '0, BoundMax, BoundMax);
    send_word(FuncQuery, '0, '0, BoundMax - 3);
    send_word(FuncQuery, '0, '0, BoundMax - 4);
    send_word(FuncQuery, '0, '0, 63'd1000);
    send_word(FuncQuery, '0, '0, 63'd999);
    send_word(FuncQuery, '0, '0, 63'd1001);
    // inverted range matches nothing in between or at its ends
    send_word(FuncLoad, 63'd200, 63'd100, '0);
    send_word(FuncQuery, '0, '0, 63'd150);
    send_word(FuncQuery, '0, '0, 63'd100);
    send_word(FuncQuery, '0, '0, 63'd200);
    send_word(FuncQuery, '0, '0, 63'h2AAA_AAAA_AAAA_AAAA);

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        drain();
        sender_gap_pct = 79;
        stall_pct      = 18;
      end else if (n == 2 * RandomItems / 3) begin
        drain();
        sender_gap_pct = 0;
        stall_pct      = 0;
      end
      if ($urandom_range(0, 99) < (board.bound_lo.size() < TableDepth ? 40 : 10))
        send_random_load();
      else
        send_random_query();
    end

    drain();
    repeat (TableDepth + 16) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
